FILE: sv/bdca_pkg.sv
package bdca_pkg;

  // event codes carried in the func field of an input beat
  typedef enum logic [1:0] {
    FUNC_EVT_START = 2'd0,
    FUNC_TX_HDR    = 2'd1,
    FUNC_IFS       = 2'd2,
    FUNC_PKT_RX    = 2'd3
  } func_e;

  // configuration register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 1;
  localparam logic [CfgAddrW-1:0] CFG_ROLE        = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_RSSI_SAMPLE = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_LATENCY     = 2'd2;

  localparam logic ROLE_MASTER = 1'b0;

  // data channel pdu header fields
  localparam logic [1:0] LLID_CONT    = 2'd1;
  localparam int unsigned HdrNesnBit  = 2;
  localparam int unsigned HdrSnBit    = 3;
  localparam int unsigned HdrMdBit    = 4;
  localparam logic [7:0] EMPTY_PDU_SIZE = 8'd2;

  typedef struct packed {
    func_e      func;
    logic       rx_window_expired;
    logic       crc_ok;
    logic [7:0] pkt_size;
    logic [7:0] pkt_header;
    logic [7:0] head_length;
    logic [7:0] tx_queue_len;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_header;
    logic       make_empty;
    logic       deliver_rx;
    logic       pop_tx;
    logic       capture_anchor;
    logic       radio_rx;
    logic       use_ifs;
    logic       sample_rssi;
    logic       go_on;
  } out_item_t;

  typedef struct packed {
    logic role;
    logic rssi_sample_enable;
    logic latency_skip_en;
  } cfg_t;

  typedef struct packed {
    logic seq_bit;
    logic next_expected_bit;
    logic peer_more_data;
    logic event_done;
    logic last_rx_good;
    logic last_rx_empty;
  } flags_t;

endpackage

FILE: sv/bdca_stream_if.sv
interface bdca_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

FILE: sv/bdca_core.sv
module bdca_core #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  bdca_pkg::in_item_t        item_i,
  input  bdca_pkg::cfg_t            cfg_i,
  input  bdca_pkg::flags_t          flags_i,
  input  logic [COUNT_BITS-1:0]     count_i,
  output bdca_pkg::flags_t          flags_o,
  output logic [COUNT_BITS-1:0]     count_o,
  output bdca_pkg::out_item_t       res_o
);
  import bdca_pkg::*;

  logic      q_nonempty;
  logic      q_empty;
  logic      rx_ok;
  logic      rx_empty;
  logic      peer_sn;
  logic      peer_nesn;
  logic      pop;
  logic      odd;
  logic      below_two;
  out_item_t act;

  assign q_empty   = (item_i.tx_queue_len == 8'd0);
  assign rx_ok     = item_i.crc_ok && (item_i.pkt_size[7:1] != 7'd0);
  assign rx_empty  = (item_i.pkt_size == EMPTY_PDU_SIZE) &&
                     (item_i.pkt_header[1:0] == LLID_CONT);
  assign peer_sn   = item_i.pkt_header[HdrSnBit];
  assign peer_nesn = item_i.pkt_header[HdrNesnBit];

  // event update and per-event actions
  always_comb begin
    flags_o    = flags_i;
    count_o    = count_i;
    act        = '0;
    pop        = 1'b0;
    q_nonempty = !q_empty;
    unique case (item_i.func)
      FUNC_EVT_START: begin
        flags_o.event_done   = 1'b0;
        flags_o.last_rx_good = 1'b0;
        count_o              = '0;
      end
      FUNC_TX_HDR: begin
        act.make_empty            = q_empty;
        act.tx_header[1:0]        = q_empty ? LLID_CONT : item_i.pkt_header[1:0];
        act.tx_header[HdrMdBit]   = !q_empty && ((item_i.head_length != 8'd0) ||
                                    (item_i.tx_queue_len[7:1] != 7'd0));
        act.tx_header[HdrNesnBit] = flags_i.next_expected_bit;
        act.tx_header[HdrSnBit]   = flags_i.seq_bit;
        q_nonempty                = 1'b1;
      end
      FUNC_IFS: begin
        if (item_i.rx_window_expired) begin
          flags_o.event_done = 1'b1;
        end else if (count_i != '1) begin
          count_o = count_i + 1'b1;
        end
      end
      FUNC_PKT_RX: begin
        act.capture_anchor = (count_i[COUNT_BITS-1:1] == '0);
        if (!rx_ok) begin
          flags_o.last_rx_empty = 1'b0;
          flags_o.last_rx_good  = 1'b0;
        end else begin
          flags_o.last_rx_good      = 1'b1;
          flags_o.last_rx_empty     = rx_empty;
          act.deliver_rx            = (flags_i.next_expected_bit == peer_sn) && !rx_empty;
          flags_o.peer_more_data    = item_i.pkt_header[HdrMdBit];
          flags_o.next_expected_bit = !peer_sn;
          if (peer_nesn != flags_i.seq_bit) begin
            flags_o.seq_bit = !flags_i.seq_bit;
            pop             = 1'b1;
          end
        end
        act.pop_tx = pop;
        // queue length minus the pop
        q_nonempty = pop ? (item_i.tx_queue_len[7:1] != 7'd0) : !q_empty;
      end
      default: ;
    endcase
  end

  assign odd       = count_o[0];
  assign below_two = (count_o[COUNT_BITS-1:1] == '0);

  // radio decision on the updated state
  always_comb begin
    res_o             = act;
    res_o.radio_rx    = 1'b0;
    res_o.use_ifs     = 1'b0;
    res_o.sample_rssi = 1'b0;
    res_o.go_on       = 1'b0;
    if (!flags_o.event_done) begin
      res_o.use_ifs = (count_o != '0);
      if (cfg_i.role == ROLE_MASTER) begin
        res_o.radio_rx    = odd;
        res_o.sample_rssi = cfg_i.rssi_sample_enable && below_two && odd;
        res_o.go_on       = below_two || q_nonempty || flags_o.peer_more_data;
      end else begin
        res_o.radio_rx    = !odd;
        res_o.sample_rssi = cfg_i.rssi_sample_enable && (count_o == '0);
        res_o.go_on       = q_nonempty || flags_o.peer_more_data ||
                            (odd && (!flags_o.last_rx_good || !flags_o.last_rx_empty)) ||
                            (below_two && !cfg_i.latency_skip_en);
      end
    end
  end

endmodule

FILE: sv/ble_data_channel_ack_flow_top.sv
// link layer acknowledgement and flow control for one ble data channel connection,
// master or slave role. each input beat is one event (event start, tx header request,
// inter-frame event, packet received); each one gives exactly one result beat with the
// header byte to send, the queue actions and the radio decision for the next operation.
// the block keeps sn, nesn, peer md, the exchange count (saturating, COUNT_BITS wide) and
// the last-receive flags. an event is taken into an input register, worked out in flag
// logic and placed in a result register: one event per cycle is sustained while out_if is
// ready. a stalled result does not stop the next event from entering an empty input
// register, but an event held there waits for the result to drain. configuration writes
// must be made while no event is in flight.
module ble_data_channel_ack_flow_top #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bdca_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  logic [bdca_pkg::CfgDataW-1:0]      cfg_wdata_i,
  bdca_stream_if.sink                        in_if,
  bdca_stream_if.source                      out_if
);
  import bdca_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  // input stage
  logic     s1_valid_q;
  in_item_t s1_item_q;
  logic     s1_advance;

  // result stage
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res;

  // link state
  flags_t                flags_q;
  flags_t                flags_d;
  logic [COUNT_BITS-1:0] count_q;
  logic [COUNT_BITS-1:0] count_d;

  // only bit 0 of the data is kept, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ROLE:        cfg_q.role               <= cfg_wdata_i[0];
        CFG_RSSI_SAMPLE: cfg_q.rssi_sample_enable <= cfg_wdata_i[0];
        CFG_LATENCY:     cfg_q.latency_skip_en    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // the input register moves on whenever the result register is free or being drained
  assign s1_advance  = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      s1_item_q <= in_if.payload;
    end
  end

  bdca_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .item_i  (s1_item_q),
    .cfg_i   (cfg_q),
    .flags_i (flags_q),
    .count_i (count_q),
    .flags_o (flags_d),
    .count_o (count_d),
    .res_o   (res)
  );

  // state commits in the same cycle as the result beat is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      count_q <= '0;
    end else if (s1_advance) begin
      flags_q <= flags_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_if.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_q <= res;
    end
  end

  assign out_if.valid   = out_valid_q;
  assign out_if.payload = out_q;

  // an event start always leaves the exchange count at zero
  a_start_clears_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_advance && (s1_item_q.func == FUNC_EVT_START) |=> (count_q == '0)
  ) else $error("exchange count not cleared by event start");

  // the count saturates: from all ones it only stays or restarts at zero
  a_count_saturates: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (count_q == '1) |=> (count_q == '1) || (count_q == '0)
  ) else $error("exchange count wrapped");

  // an acknowledge toggles our sequence bit
  a_pop_toggles_sn: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_advance && res.pop_tx |=> (flags_q.seq_bit != $past(flags_q.seq_bit))
  ) else $error("pop without sn toggle");

  // once the event is done no further radio operation is requested
  a_done_no_go: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> !flags_q.event_done || (!out_q.go_on && !out_q.radio_rx)
  ) else $error("radio activity after event done");

  // a beat that is not a receive never acts on the queues
  a_queue_actions_on_rx: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s1_advance && (s1_item_q.func != FUNC_PKT_RX) |=> !out_q.pop_tx && !out_q.deliver_rx
  ) else $error("queue action outside packet receive");

endmodule
